@@ rtl/core/rbrh_pkg.sv @@
// ----------------------------------------------------------------------------
// rbrh_pkg: shared types and constants of the road block hit test
// Holds the word that travels along the cell chain and the register map codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rbrh_pkg;

    localparam int unsigned ADDR_W     = 6;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned BLK_IDX_W  = 4;
    localparam int unsigned MAX_BLOCKS = 16;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Register bank select, taken from the upper two address bits
    localparam logic [1:0] BANK_X    = 2'd0;
    localparam logic [1:0] BANK_Y    = 2'd1;
    localparam logic [1:0] BANK_SIZE = 2'd2;

    // Height is this base minus the low nibble of the size byte
    localparam logic [4:0] HEIGHT_BASE = 5'd16;

    // One word in flight along the chain
    typedef struct packed {
        logic              valid;
        logic              command;
        logic [ADDR_W-1:0] reg_address;
        logic [BYTE_W-1:0] write_data;
        logic [BYTE_W-1:0] pixel_x;
        logic [BYTE_W-1:0] pixel_y;
        logic              hit;
    } token_t;

endpackage

`default_nettype wire

@@ rtl/core/road_block_rectangle_hit.sv @@
// ----------------------------------------------------------------------------
// road_block_rectangle_hit: road block generator pixel hit test
// Chain of block cells; register writes and pixel queries flow through it.
// ----------------------------------------------------------------------------
// Every word (register write or pixel query) enters a chain of NUM_BLOCKS
// cells, one per road block, and moves one cell per cycle unless the chain
// holds; its result leaves after passing the register of every cell. A new
// word is accepted every cycle while the result side takes results; the
// whole chain holds as one when a waiting result is stalled. Writes update
// a cell as they pass it, so every query sees exactly the writes accepted
// before it. Writes to bytes 48 to 63, or to blocks at or beyond NUM_BLOCKS,
// have no visible effect. A write returns road_pixel 0.
`default_nettype none

module road_block_rectangle_hit #(
    parameter int unsigned NUM_BLOCKS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    output logic                                 req_stall,
    input  wire logic                            command,
    input  wire logic [rbrh_pkg::ADDR_W-1:0]     reg_address,
    input  wire logic [rbrh_pkg::BYTE_W-1:0]     write_data,
    input  wire logic [rbrh_pkg::BYTE_W-1:0]     pixel_x,
    input  wire logic [rbrh_pkg::BYTE_W-1:0]     pixel_y,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_stall,
    output logic                                 road_pixel
);
    import rbrh_pkg::*;

    token_t chain [0:NUM_BLOCKS];
    logic   adv;

    // Hold the whole chain while the last result waits
    assign adv       = !(chain[NUM_BLOCKS].valid && rsp_stall);
    assign req_stall = !adv;

    // Build the entry word
    always_comb
    begin
        chain[0].valid       = req_valid;
        chain[0].command     = command;
        chain[0].reg_address = reg_address;
        chain[0].write_data  = write_data;
        chain[0].pixel_x     = pixel_x;
        chain[0].pixel_y     = pixel_y;
        chain[0].hit         = 1'b0;
    end

    for (genvar i = 0; i < NUM_BLOCKS; i++)
    begin : g_cell
        rbrh_cell #(
            .IDX (i)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .tok_i (chain[i]),
            .tok_o (chain[i+1])
        );
    end

    assign rsp_valid  = chain[NUM_BLOCKS].valid;
    assign road_pixel = chain[NUM_BLOCKS].hit;

    // A write word never reports a hit
    a_write_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && chain[NUM_BLOCKS].command == CMD_WRITE) |-> !road_pixel)
        else $error("write word left the chain with a hit");

    // Input is held back only by a stalled waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (rsp_valid && rsp_stall))
        else $error("input stalled without a waiting result");

    // A word held in the first cell moves into the second on the next cycle when the chain advances
    a_chain_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && chain[1].valid) |=> (chain[NUM_BLOCKS >= 2 ? 2 : 1].valid ||
                                     NUM_BLOCKS < 2))
        else $error("word lost inside the chain");

endmodule

`default_nettype wire

@@ rtl/core/rbrh_cell.sv @@
// ----------------------------------------------------------------------------
// rbrh_cell: one road block of the chain
// Holds the start x, start y and size byte of its block, takes writes aimed
// at them as they pass, and ORs its own hit into passing pixel queries.
// ----------------------------------------------------------------------------
`default_nettype none

module rbrh_cell #(
    parameter int unsigned IDX = 0
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            adv,
    input  wire rbrh_pkg::token_t tok_i,
    output rbrh_pkg::token_t     tok_o
);
    import rbrh_pkg::*;

    logic [BYTE_W-1:0] sx_reg;
    logic [BYTE_W-1:0] sy_reg;
    logic [BYTE_W-1:0] sz_reg;
    logic              valid_reg;
    token_t            pay_reg;
    token_t            pay_next;

    logic [3:0]        width;
    logic [4:0]        height;
    logic [BYTE_W:0]   x_end;
    logic [BYTE_W:0]   y_end;
    logic              mine;
    logic              addr_match;
    logic              is_write;

    // Test the passing pixel against this block, end bounds exclusive
    always_comb
    begin
        width  = sz_reg[7:4];
        height = HEIGHT_BASE - {1'b0, sz_reg[3:0]};
        x_end  = {1'b0, sx_reg} + {5'b0, width};
        y_end  = {1'b0, sy_reg} + {4'b0, height};
        mine   = (tok_i.pixel_x >= sx_reg) && ({1'b0, tok_i.pixel_x} < x_end) &&
                 (tok_i.pixel_y >= sy_reg) && ({1'b0, tok_i.pixel_y} < y_end);
        addr_match = (tok_i.reg_address[BLK_IDX_W-1:0] == IDX[BLK_IDX_W-1:0]);
        is_write   = tok_i.valid && (tok_i.command == CMD_WRITE) && addr_match;
    end

    // Capture writes aimed at this block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg <= '0;
            sy_reg <= '0;
            sz_reg <= '0;
        end
        else if (adv && is_write)
        begin
            case (tok_i.reg_address[ADDR_W-1:BLK_IDX_W])
                BANK_X:    sx_reg <= tok_i.write_data;
                BANK_Y:    sy_reg <= tok_i.write_data;
                BANK_SIZE: sz_reg <= tok_i.write_data;
                default:   ;
            endcase
        end
    end

    // Fold this block's hit into the passing word
    always_comb
    begin
        pay_next     = tok_i;
        pay_next.hit = tok_i.hit | ((tok_i.command == CMD_QUERY) & mine);
    end

    // Advance the word to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= tok_i.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pay_reg <= pay_next;
        end
    end

    always_comb
    begin
        tok_o       = pay_reg;
        tok_o.valid = valid_reg;
    end

endmodule

`default_nettype wire
